// ----- rtl/core/ble_beacon_tracking_table_top_macros.svh -----
// Assertion macros for the beacon tracking table checker.
`ifndef BLE_BEACON_TRACKING_TABLE_TOP_MACROS_SVH
`define BLE_BEACON_TRACKING_TABLE_TOP_MACROS_SVH
// assert that a implies b in the same cycle
`define BBT_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("check failed");
// assert that a implies b in the next cycle
`define BBT_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("check failed");
`endif

// ----- rtl/core/bbt_pkg.sv -----
// Shared types and constants of the beacon tracking table.
`default_nettype none
package bbt_pkg;
  localparam int TableDepth = 64;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);
  localparam logic [15:0] MakerIdReset = 16'h09C8;
  localparam logic [31:0] TimeoutReset = 32'd30000;
  localparam logic [4:0] MinDataLen = 5'd2;

  localparam logic [2:0] OUT_FILTERED = 3'd0;
  localparam logic [2:0] OUT_UPDATED  = 3'd1;
  localparam logic [2:0] OUT_NEW      = 3'd2;
  localparam logic [2:0] OUT_FULL     = 3'd3;
  localparam logic [2:0] OUT_SWEEP    = 3'd4;

  localparam logic CMD_REPORT = 1'b0;
  localparam logic CMD_SWEEP  = 1'b1;

  localparam logic REG_MAKER_ID = 1'b0;
  localparam logic REG_TIMEOUT  = 1'b1;

  // one memory word: all per-slot payload
  typedef struct packed {
    logic [47:0] mac;
    logic [7:0]  sig;
    logic [31:0] first_seen;
    logic [31:0] last_seen;
    logic [15:0] hits;
  } entry_t;

  typedef struct packed {
    logic           wr;
    logic [IdxW-1:0] waddr;
    entry_t         wdata;
    logic [IdxW-1:0] raddr;
  } mem_req_t;
endpackage
`default_nettype wire

// ----- rtl/core/ble_beacon_tracking_table_top.sv -----
// Top level of the beacon tracking table.
// Usage:
//  - Configuration: write wr_en/wr_index/wr_data while idle; index 0 is the
//    maker id (16 bit), index 1 the stale timeout in ms.
//  - Command: drive the input word with start high; it is taken when busy is
//    low. command 0 is a report, 1 an aging sweep.
//  - Result: one word per command on the outcome ports, flagged by done for
//    one cycle; the receiver cannot stall it.
// Timing: the engine scans the entry memory one slot per cycle through its
//  single read port (registered read); a report scan stops at the first
//  matching slot, while a sweep reads every used slot. done comes in the
//  first cycle with busy low, and a new word can be taken in that cycle.
// Active count is kept as a running counter; activity bits are flip-flops
//  cleared by reset. Memory contents are undefined after reset; only slots
//  below the used count are ever checked.
// Reset: rst (synchronous) clears counts, activity bits and the sequencer, and
//  sets the maker id and timeout registers to their defaults.
`default_nettype none
module ble_beacon_tracking_table_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  wire logic        wr_index,
  input  wire logic [31:0] wr_data,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        command,
  input  wire logic [31:0] now_ms,
  input  wire logic [47:0] mac_address,
  input  wire logic signed [7:0] signal_dbm,
  input  wire logic        has_maker_data,
  input  wire logic [4:0]  maker_data_length,
  input  wire logic [7:0]  maker_byte_low,
  input  wire logic [7:0]  maker_byte_high,
  output logic             done,
  output logic [2:0]       outcome,
  output logic [5:0]       entry_index,
  output logic [15:0]      hit_total,
  output logic [6:0]       entries_used,
  output logic [6:0]       entries_active,
  output logic [31:0]      reports_seen
);
  localparam int IW = bbt_pkg::IdxW;
  localparam int CW = bbt_pkg::CntW;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_SWEEP = 5'b00100,
    S_WRITE = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;
  logic [15:0] maker_id;
  logic [31:0] timeout;
  logic [CW-1:0] used, active_cnt;
  logic [31:0] report_count;
  logic [bbt_pkg::TableDepth-1:0] active;

  // latched command
  logic [31:0] now_q;
  logic [47:0] mac_q;
  logic [7:0]  sig_q;
  logic [CW-1:0] addr;   // next slot to read
  logic [CW-1:0] chk;    // slot whose data is now on rdata
  logic          chk_v;
  logic          hit_q;
  logic [IW-1:0] hit_idx;
  bbt_pkg::entry_t hit_ent;  // word of the matching slot
  logic [2:0]    res_code;
  logic [IW-1:0] res_idx;
  logic [15:0]   res_hits;

  bbt_pkg::mem_req_t req;
  bbt_pkg::entry_t   rdata;
  bbt_entry_ram u_ram (.clk(clk), .req(req), .rdata(rdata));

  logic keep;
  assign keep = has_maker_data && (maker_data_length >= bbt_pkg::MinDataLen) &&
                ({maker_byte_high, maker_byte_low} == maker_id);
  logic [31:0] age;
  assign age = now_q - rdata.last_seen;
  logic chk_idx_act;
  assign chk_idx_act = active[chk[IW-1:0]];

  bbt_pkg::entry_t upd;
  always_comb begin
    upd = hit_ent;
    upd.sig = sig_q;
    upd.last_seen = now_q;
    upd.hits = hit_ent.hits + 16'd1;
    if (!hit_q) begin
      upd.mac = mac_q;
      upd.first_seen = now_q;
      upd.hits = 16'd1;
    end
  end

  always_comb begin
    req.wr = (state == S_WRITE);
    req.waddr = hit_q ? hit_idx : used[IW-1:0];
    req.wdata = upd;
    req.raddr = addr[IW-1:0];
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      maker_id <= bbt_pkg::MakerIdReset;
      timeout <= bbt_pkg::TimeoutReset;
      used <= '0;
      active_cnt <= '0;
      report_count <= '0;
      active <= '0;
      done <= 1'b0;
      chk_v <= 1'b0;
    end else begin
      done <= 1'b0;
      if (wr_en) begin
        if (wr_index == bbt_pkg::REG_MAKER_ID) maker_id <= wr_data[15:0];
        else timeout <= wr_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            now_q <= now_ms; mac_q <= mac_address; sig_q <= signal_dbm;
            addr <= '0; chk_v <= 1'b0; hit_q <= 1'b0;
            res_idx <= '0; res_hits <= '0;
            if (command == bbt_pkg::CMD_SWEEP) begin
              res_code <= bbt_pkg::OUT_SWEEP;
              state <= S_SWEEP;
            end else begin
              report_count <= report_count + 32'd1;
              if (keep) state <= S_SCAN;
              else begin
                res_code <= bbt_pkg::OUT_FILTERED;
                state <= S_DONE;
              end
            end
          end
        end
        S_SCAN: begin
          chk <= addr; chk_v <= (addr < used);
          addr <= addr + 1'b1;
          if (chk_v && rdata.mac == mac_q) begin
            hit_q <= 1'b1; hit_idx <= chk[IW-1:0];
            hit_ent <= rdata;
            state <= S_WRITE;
          end else if (chk_v ? (chk + 1'b1 >= used) : (used == '0 && addr != '0)) begin
            if (used == CW'(bbt_pkg::TableDepth)) begin
              res_code <= bbt_pkg::OUT_FULL;
              state <= S_DONE;
            end else state <= S_WRITE;
          end
        end
        S_SWEEP: begin
          chk <= addr; chk_v <= (addr < used);
          addr <= addr + 1'b1;
          if (chk_v) begin
            if (age > timeout && chk_idx_act) begin
              active[chk[IW-1:0]] <= 1'b0;
              active_cnt <= active_cnt - 1'b1;
            end
            if (chk + 1'b1 >= used) state <= S_DONE;
          end else if (used == '0 && addr != '0) state <= S_DONE;
        end
        S_WRITE: begin
          if (hit_q) begin
            res_code <= bbt_pkg::OUT_UPDATED;
            res_idx <= hit_idx;
            res_hits <= upd.hits;
            if (!active[hit_idx]) active_cnt <= active_cnt + 1'b1;
            active[hit_idx] <= 1'b1;
          end else begin
            res_code <= bbt_pkg::OUT_NEW;
            res_idx <= used[IW-1:0];
            res_hits <= 16'd1;
            active[used[IW-1:0]] <= 1'b1;
            active_cnt <= active_cnt + 1'b1;
            used <= used + 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign outcome = res_code;
  assign entry_index = 6'(res_idx);
  assign hit_total = res_hits;
  assign entries_used = 7'(used);
  assign entries_active = 7'(active_cnt);
  assign reports_seen = report_count;
endmodule
`default_nettype wire

// ----- rtl/core/bbt_entry_ram.sv -----
// Single-port-write, registered-read entry memory.
`default_nettype none
module bbt_entry_ram (
  input  wire logic            clk,
  input  wire bbt_pkg::mem_req_t req,
  output bbt_pkg::entry_t      rdata
);
  bbt_pkg::entry_t mem [bbt_pkg::TableDepth];
  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/core/bbt_checker.sv -----
// Port-level checker for the beacon tracking table, bound to the top level.
`default_nettype none
`include "ble_beacon_tracking_table_top_macros.svh"
module bbt_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic [2:0] outcome,
  input wire logic [5:0] entry_index,
  input wire logic [15:0] hit_total,
  input wire logic [6:0] entries_used,
  input wire logic [6:0] entries_active
);
  // result word that names no slot
  logic quiet_out;
  assign quiet_out = done && outcome != bbt_pkg::OUT_UPDATED &&
                     outcome != bbt_pkg::OUT_NEW;

  `BBT_ASSERT_NXT(a_take_busy, start && !busy, busy)
  `BBT_ASSERT_IMP(a_active_le_used, 1'b1, entries_active <= entries_used)
  `BBT_ASSERT_IMP(a_quiet_idx, quiet_out, entry_index == 6'd0 && hit_total == 16'd0)
  `BBT_ASSERT_NXT(a_done_pulse, done, !done)
endmodule
bind ble_beacon_tracking_table_top bbt_checker u_bbt_checker (.*);
`default_nettype wire
